@@ src/lud_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the lens undistortion unit.
// Depends on nothing; every other file of the block imports it.
package lud_pkg;

  localparam int ITERS     = 20;  // undistortion iterations
  localparam int DIV_STEPS = 33;  // quotient bits produced by the divider row

  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] PIX_MAX = 64'sd34359738367;
  localparam logic signed [63:0] PIX_MIN = -64'sd34359738368;

  typedef enum logic [2:0] {
    REG_FOCAL,
    REG_PRINCIPAL,
    REG_RADIAL,
    REG_TANGENTIAL,
    REG_HROW0,
    REG_HROW1,
    REG_HROW2
  } cfg_reg_t;

  // Sideband that travels with every item through the pipeline.
  typedef struct packed {
    logic              valid;
    logic              bad;
    logic signed [31:0] xd;
    logic signed [31:0] yd;
  } ctx_t;

  // Sign and magnitudes handed to a divider.
  typedef struct packed {
    logic        neg;
    logic [56:0] un;
    logic [56:0] ud;
  } dreq_t;

  // One lane of a division in flight.
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [56:0] rem;
    logic [56:0] den;
    logic [32:0] lo;
    logic [32:0] quo;
  } dl_t;

  typedef struct packed {
    logic signed [20:0] k1;
    logic signed [20:0] k2;
    logic signed [20:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return t[31:0];
  endfunction

  function automatic logic signed [35:0] sat36(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > PIX_MAX) ? PIX_MAX : ((v < PIX_MIN) ? PIX_MIN : v);
    return t[35:0];
  endfunction

  function automatic logic [30:0] clamp31(input logic [63:0] v);
    return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
  endfunction

  function automatic logic [56:0] mag57(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v < 0) ? -v : v;
    return t[56:0];
  endfunction

endpackage

@@ src/lud_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring division step for the x and y lanes, registered.
// Depends on lud_pkg.
module lud_div_cell import lud_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  ctx_t ctx_in,
  input  dl_t  lx_in,
  input  dl_t  ly_in,
  output ctx_t ctx_out,
  output dl_t  lx_out,
  output dl_t  ly_out
);

  function automatic dl_t div_step(input dl_t d);
    logic [57:0] r2;
    logic [57:0] diff;
    logic        ge;
    dl_t         o;
    r2   = {d.rem, d.lo[32]};
    diff = r2 - {1'b0, d.den};
    ge   = r2 >= {1'b0, d.den};
    o     = d;
    o.rem = ge ? diff[56:0] : r2[56:0];
    o.lo  = {d.lo[31:0], 1'b0};
    o.quo = {d.quo[31:0], ge};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out <= '0;
    end else if (en) begin
      ctx_out <= ctx_in;
      lx_out  <= div_step(lx_in);
      ly_out  <= div_step(ly_in);
    end
  end

endmodule

@@ src/lud_div.sv @@
`timescale 1ns / 1ps
// Pipelined two-lane saturating divider: entry stage, a row of step cells, exit stage.
// Depends on lud_pkg and lud_div_cell.
module lud_div import lud_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               frac16,
  input  ctx_t               ctx_in,
  input  dreq_t              req_x,
  input  dreq_t              req_y,
  output ctx_t               ctx_out,
  output logic signed [31:0] qx,
  output logic signed [31:0] qy
);

  ctx_t cc [0:DIV_STEPS];
  dl_t  lx [0:DIV_STEPS];
  dl_t  ly [0:DIV_STEPS];

  // The dividend is the magnitude shifted up by the fraction bits. Its part above
  // the quotient bits must stay below the divisor, or the result saturates.
  function automatic dl_t div_entry(input dreq_t r, input logic f16);
    logic [84:0] n;
    dl_t         d;
    n = f16 ? {12'd0, r.un, 16'd0} : {r.un, 28'd0};
    d.neg = r.neg;
    d.ovf = {5'd0, n[84:33]} >= r.ud;
    d.rem = {5'd0, n[84:33]};
    d.den = r.ud;
    d.lo  = n[32:0];
    d.quo = '0;
    return d;
  endfunction

  function automatic logic signed [31:0] div_result(input dl_t d);
    logic [32:0] m;
    logic [32:0] nm;
    m  = (d.ovf || d.quo > 33'h0_8000_0000) ? 33'h0_8000_0000 : d.quo;
    nm = -m;
    if (d.neg) begin
      return nm[31:0];
    end
    return (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cc[0] <= '0;
    end else if (en) begin
      cc[0] <= ctx_in;
      lx[0] <= div_entry(req_x, frac16);
      ly[0] <= div_entry(req_y, frac16);
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    lud_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctx_in  (cc[i]),
      .lx_in   (lx[i]),
      .ly_in   (ly[i]),
      .ctx_out (cc[i+1]),
      .lx_out  (lx[i+1]),
      .ly_out  (ly[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out <= '0;
    end else if (en) begin
      ctx_out <= cc[DIV_STEPS];
      qx      <= div_result(lx[DIV_STEPS]);
      qy      <= div_result(ly[DIV_STEPS]);
    end
  end

endmodule

@@ src/lud_iter.sv @@
`timescale 1ns / 1ps
// One undistortion iteration: radial and tangential terms, then the divide by kr.
// Depends on lud_pkg and lud_div.
module lud_iter import lud_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  coef_t              coef,
  input  ctx_t               ctx_in,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  output ctx_t               ctx_out,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out
);

  ctx_t c1, c2, c3, c4, c5, c6, c7, c8, cd;
  logic signed [63:0] pxx, pyy, pxy;
  logic [30:0]        r2_2, r2_3, r2_4, xx27, yy27;
  logic signed [31:0] xy2;
  logic [61:0]        pr4, pr6;
  logic [30:0]        tx, ty, r4, r6;
  logic signed [63:0] pa, pb, pc, pd, pa4, pd4;
  logic signed [51:0] mk1_3, mk1_4, mk1_5, mk1_6, mk1_7;
  logic signed [51:0] mk2_5, mk2_6, mk2_7, mk3;
  logic signed [31:0] dx5, dy5, dx6, dy6, dx7, dy7;
  logic signed [31:0] kr;
  logic signed [32:0] numx, numy;
  dreq_t              rqx, rqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0; c2 <= '0; c3 <= '0; c4 <= '0;
      c5 <= '0; c6 <= '0; c7 <= '0; c8 <= '0;
    end else if (en) begin
      c1 <= ctx_in;
      pxx <= x_in * x_in;
      pyy <= y_in * y_in;
      pxy <= x_in * y_in;

      c2   <= c1;
      r2_2 <= clamp31((64'(unsigned'(pxx)) + 64'(unsigned'(pyy))) >> 28);
      xx27 <= clamp31(64'(unsigned'(pxx)) >> 27);
      yy27 <= clamp31(64'(unsigned'(pyy)) >> 27);
      xy2  <= sat32(pxy >>> 27);

      c3    <= c2;
      r2_3  <= r2_2;
      pr4   <= r2_2 * r2_2;
      tx    <= clamp31(64'(r2_2) + 64'(xx27));
      ty    <= clamp31(64'(r2_2) + 64'(yy27));
      pa    <= coef.p1 * xy2;
      pd    <= coef.p2 * xy2;
      mk1_3 <= coef.k1 * $signed({1'b0, r2_2});

      c4    <= c3;
      r2_4  <= r2_3;
      r4    <= clamp31(64'(pr4) >> 28);
      pb    <= coef.p2 * $signed({1'b0, tx});
      pc    <= coef.p1 * $signed({1'b0, ty});
      pa4   <= pa;
      pd4   <= pd;
      mk1_4 <= mk1_3;

      c5    <= c4;
      pr6   <= r4 * r2_4;
      mk2_5 <= coef.k2 * $signed({1'b0, r4});
      mk1_5 <= mk1_4;
      dx5   <= sat32((pa4 >>> 30) + (pb >>> 30));
      dy5   <= sat32((pc >>> 30) + (pd4 >>> 30));

      c6    <= c5;
      r6    <= clamp31(64'(pr6) >> 28);
      mk1_6 <= mk1_5;
      mk2_6 <= mk2_5;
      dx6   <= dx5;
      dy6   <= dy5;

      c7    <= c6;
      mk3   <= coef.k3 * $signed({1'b0, r6});
      mk1_7 <= mk1_6;
      mk2_7 <= mk2_6;
      dx7   <= dx6;
      dy7   <= dy6;

      c8   <= c7;
      kr   <= sat32(64'(mk1_7 >>> 17) + 64'(mk2_7 >>> 17) + 64'(mk3 >>> 17) + ONE_Q28);
      numx <= $signed({c7.xd[31], c7.xd}) - $signed({dx7[31], dx7});
      numy <= $signed({c7.yd[31], c7.yd}) - $signed({dy7[31], dy7});
    end
  end

  // A zero radial factor marks the item bad; later values are don't-care.
  always_comb begin
    cd     = c8;
    cd.bad = c8.bad || (kr == 32'sd0);
    rqx.neg = numx[32] ^ kr[31];
    rqx.un  = mag57(64'(numx));
    rqx.ud  = mag57(64'(kr));
    rqy.neg = numy[32] ^ kr[31];
    rqy.un  = mag57(64'(numy));
    rqy.ud  = mag57(64'(kr));
  end

  lud_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .frac16  (1'b0),
    .ctx_in  (cd),
    .req_x   (rqx),
    .req_y   (rqy),
    .ctx_out (ctx_out),
    .qx      (x_out),
    .qy      (y_out)
  );

endmodule

@@ src/lens_undistort_homography_unit.sv @@
`timescale 1ns / 1ps
// Top level of the lens undistortion and homography unit.
// Depends on lud_pkg, lud_div and lud_iter.

// A fully pipelined unit that accepts one pixel per clock unless its output skid
// entry is occupied, and returns one world point per pixel, in order. It is a
// chain of 20 iteration cells (43 stages each, of which 35 are the divider: an
// entry stage, 33 per-bit cells and an exit stage) between the normalizing and
// perspective dividers. A two-entry output buffer keeps the input open while a
// result waits. Configuration writes must be made only while no pixel is in flight.
module lens_undistort_homography_unit import lud_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        pixel_x,
  input  logic [15:0]        pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic               invalid
);

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic               inv;
  } res_t;

  logic [63:0] focal, principal, tangential;
  logic [62:0] radial;
  logic [62:0] hrow [0:2];
  logic [31:0] fx, fy, cx, cy;
  logic signed [20:0] hm [0:2][0:2];
  coef_t coef;
  logic  en;

  ctx_t  c0, nc, ncd;
  dreq_t n_rqx, n_rqy;
  logic signed [31:0] nqx, nqy;

  ctx_t ic [0:ITERS];
  logic signed [31:0] ix [0:ITERS];
  logic signed [31:0] iy [0:ITERS];

  ctx_t rc1, rc2, rc3, rc4, rc5, fc;
  logic signed [63:0] mx, my;
  logic signed [35:0] u, v;
  logic signed [56:0] hu [0:2];
  logic signed [56:0] hv [0:2];
  logic signed [57:0] acc [0:2];
  dreq_t f_rqx, f_rqy;
  logic signed [31:0] fqx, fqy;

  res_t res_new, out_r, skid_r;
  logic skid_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal      <= 64'd4503599628419072;
      principal  <= '0;
      radial     <= '0;
      tangential <= '0;
      hrow[0]    <= 63'd8192;
      hrow[1]    <= 63'd17179869184;
      hrow[2]    <= 63'd36028797018963968;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL:      focal      <= cfg_data;
        REG_PRINCIPAL:  principal  <= cfg_data;
        REG_RADIAL:     radial     <= cfg_data[62:0];
        REG_TANGENTIAL: tangential <= cfg_data;
        REG_HROW0:      hrow[0]    <= cfg_data[62:0];
        REG_HROW1:      hrow[1]    <= cfg_data[62:0];
        REG_HROW2:      hrow[2]    <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  assign fx = focal[31:0];
  assign fy = focal[63:32];
  assign cx = principal[31:0];
  assign cy = principal[63:32];
  assign coef.k1 = radial[20:0];
  assign coef.k2 = radial[41:21];
  assign coef.k3 = radial[62:42];
  assign coef.p1 = tangential[31:0];
  assign coef.p2 = tangential[63:32];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hm[i][0] = hrow[i][20:0];
      hm[i][1] = hrow[i][41:21];
      hm[i][2] = hrow[i][62:42];
    end
  end

  // The whole pipeline advances unless the skid entry is occupied.
  assign en       = !skid_v;
  assign in_ready = en;

  // Normalization: (pixel - principal point) / focal length.
  always_ff @(posedge clk) begin
    if (rst) begin
      c0 <= '0;
    end else if (en) begin
      c0.valid <= in_valid;
      c0.bad   <= (fx == 32'd0) || (fy == 32'd0);
      c0.xd    <= '0;
      c0.yd    <= '0;
      n_rqx.ud  <= {25'd0, fx};
      n_rqy.ud  <= {25'd0, fy};
      if ({pixel_x, 16'd0} < cx) begin
        n_rqx.neg <= 1'b1;
        n_rqx.un  <= {25'd0, cx - {pixel_x, 16'd0}};
      end else begin
        n_rqx.neg <= 1'b0;
        n_rqx.un  <= {25'd0, {pixel_x, 16'd0} - cx};
      end
      if ({pixel_y, 16'd0} < cy) begin
        n_rqy.neg <= 1'b1;
        n_rqy.un  <= {25'd0, cy - {pixel_y, 16'd0}};
      end else begin
        n_rqy.neg <= 1'b0;
        n_rqy.un  <= {25'd0, {pixel_y, 16'd0} - cy};
      end
    end
  end

  lud_div u_norm_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .frac16  (1'b0),
    .ctx_in  (c0),
    .req_x   (n_rqx),
    .req_y   (n_rqy),
    .ctx_out (nc),
    .qx      (nqx),
    .qy      (nqy)
  );

  always_comb begin
    ncd    = nc;
    ncd.xd = nqx;
    ncd.yd = nqy;
  end

  assign ic[0] = ncd;
  assign ix[0] = nqx;
  assign iy[0] = nqy;

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    lud_iter u_iter (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .coef    (coef),
      .ctx_in  (ic[i]),
      .x_in    (ix[i]),
      .y_in    (iy[i]),
      .ctx_out (ic[i+1]),
      .x_out   (ix[i+1]),
      .y_out   (iy[i+1])
    );
  end

  // Back to pixels, then the homography sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      rc1 <= '0; rc2 <= '0; rc3 <= '0; rc4 <= '0; rc5 <= '0;
    end else if (en) begin
      rc1 <= ic[ITERS];
      mx  <= ix[ITERS] * $signed({1'b0, fx});
      my  <= iy[ITERS] * $signed({1'b0, fy});

      rc2 <= rc1;
      u   <= sat36((mx >>> 28) + $signed({32'd0, cx}));
      v   <= sat36((my >>> 28) + $signed({32'd0, cy}));

      rc3 <= rc2;
      for (int i = 0; i < 3; i++) begin
        hu[i] <= hm[i][0] * u;
        hv[i] <= hm[i][1] * v;
      end

      rc4 <= rc3;
      for (int i = 0; i < 3; i++) begin
        acc[i] <= 58'(hu[i]) + 58'(hv[i]) + (58'(hm[i][2]) <<< 20);
      end

      rc5.valid <= rc4.valid;
      rc5.bad   <= rc4.bad || (acc[2] == 58'sd0);
      rc5.xd    <= rc4.xd;
      rc5.yd    <= rc4.yd;
      f_rqx.neg <= acc[0][57] ^ acc[2][57];
      f_rqx.un  <= mag57(64'(acc[0]));
      f_rqx.ud  <= mag57(64'(acc[2]));
      f_rqy.neg <= acc[1][57] ^ acc[2][57];
      f_rqy.un  <= mag57(64'(acc[1]));
      f_rqy.ud  <= mag57(64'(acc[2]));
    end
  end

  lud_div u_persp_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .frac16  (1'b1),
    .ctx_in  (rc5),
    .req_x   (f_rqx),
    .req_y   (f_rqy),
    .ctx_out (fc),
    .qx      (fqx),
    .qy      (fqy)
  );

  always_comb begin
    res_new.wx  = fc.bad ? 32'sd0 : fqx;
    res_new.wy  = fc.bad ? 32'sd0 : fqy;
    res_new.inv = fc.bad;
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_v) begin
        out_r     <= skid_r;
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else if (fc.valid) begin
        out_r     <= res_new;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (en && fc.valid) begin
      skid_r <= res_new;
      skid_v <= 1'b1;
    end
  end

  assign world_x = out_r.wx;
  assign world_y = out_r.wy;
  assign invalid = out_r.inv;

endmodule

@@ dv/lens_undistort_homography_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for lens_undistort_homography_unit: directed table, then random phases
// checked against an in-bench fixed-point predictor. Depends on lud_pkg and the RTL.
module lens_undistort_homography_unit_tb;
  import lud_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // no register sits at this index
  localparam int LATENCY = 937;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic               inv;
  } world_t;

  typedef enum logic [1:0] {ROW_PIX, ROW_PIX_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [2:0]  idx;
    logic [63:0] data;
    world_t      want;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, in_valid = 0, out_ready = 0;
  logic [2:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;
  logic [15:0] pixel_x = 0, pixel_y = 0;
  logic cfg_ready, in_ready, out_valid, invalid;
  logic signed [31:0] world_x, world_y;

  logic [63:0] m_focal, m_principal, m_radial, m_tangential;
  logic [63:0] m_hrow[3];

  world_t pending_points[$];
  int mismatches = 0, points_checked = 0, cfg_writes = 0, invalid_seen = 0;
  bit ready_free = 0;  // when set the receiver never stalls

  always #5 clk = ~clk;

  lens_undistort_homography_unit dut (.*);

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // Truncating num * 2^fb / den, saturated to 32-bit signed.
  function automatic longint div_frac(longint num, longint den, int fb);
    longint unsigned lim, un, ud, q, r;
    bit neg;
    lim = 64'h8000_0000;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = un / ud;
    r = un % ud;
    for (int i = 0; i < fb && q <= lim; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
    end
    if (q > lim) q = lim;
    if (neg) return -longint'(q);
    if (q > lim - 1) q = lim - 1;
    return longint'(q);
  endfunction

  function automatic longint pow_q28(longint a, longint b);
    longint p;
    p = (a * b) >>> 28;
    return p > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : p;
  endfunction

  function automatic world_t predict_world(logic [15:0] px, logic [15:0] py);
    longint fx, fy, cx, cy, k1, k2, k3, p1, p2, xd, yd, x, y, u, v;
    longint r2, r4, r6, kr, xy2, tx, ty, dx, dy;
    longint h[3][3];
    longint acc[3];
    longint unsigned sq;
    world_t w;
    w.wx = 0;
    w.wy = 0;
    w.inv = 1;
    fx = longint'({32'b0, m_focal[31:0]});
    fy = longint'({32'b0, m_focal[63:32]});
    cx = longint'({32'b0, m_principal[31:0]});
    cy = longint'({32'b0, m_principal[63:32]});
    k1 = longint'($signed(m_radial[20:0]));
    k2 = longint'($signed(m_radial[41:21]));
    k3 = longint'($signed(m_radial[62:42]));
    p1 = longint'($signed(m_tangential[31:0]));
    p2 = longint'($signed(m_tangential[63:32]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        h[i][j] = longint'($signed(m_hrow[i][21*j +: 21]));
    if (fx == 0 || fy == 0) return w;
    xd = div_frac(longint'({px, 16'b0}) - cx, fx, 28);
    yd = div_frac(longint'({py, 16'b0}) - cy, fy, 28);
    x = xd;
    y = yd;
    for (int i = 0; i < ITERS; i++) begin
      sq = longint'(x * x) + longint'(y * y);
      sq = sq >> 28;
      r2 = sq > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(sq);
      r4 = pow_q28(r2, r2);
      r6 = pow_q28(r4, r2);
      kr = clip32((64'sd1 <<< 28) + ((k1 * r2) >>> 17) + ((k2 * r4) >>> 17)
                  + ((k3 * r6) >>> 17));
      xy2 = clip32((x * y) >>> 27);
      tx = clip32(r2 + clip32((x * x) >>> 27));
      ty = clip32(r2 + clip32((y * y) >>> 27));
      dx = clip32(((p1 * xy2) >>> 30) + ((p2 * tx) >>> 30));
      dy = clip32(((p1 * ty) >>> 30) + ((p2 * xy2) >>> 30));
      if (kr == 0) return w;
      x = div_frac(xd - dx, kr, 28);
      y = div_frac(yd - dy, kr, 28);
    end
    u = clip(((x * fx) >>> 28) + cx, -(64'sd1 <<< 35), (64'sd1 <<< 35) - 1);
    v = clip(((y * fy) >>> 28) + cy, -(64'sd1 <<< 35), (64'sd1 <<< 35) - 1);
    for (int i = 0; i < 3; i++)
      acc[i] = h[i][0] * u + h[i][1] * v + h[i][2] * (64'sd1 <<< 20);
    if (acc[2] == 0) return w;
    w.wx = 32'(div_frac(acc[0], acc[2], 16));
    w.wy = 32'(div_frac(acc[1], acc[2], 16));
    w.inv = 0;
    return w;
  endfunction

  function automatic logic [63:0] pack_q3(int a, int b, int c);
    logic [20:0] fa, fb, fc;
    fa = 21'(a);
    fb = 21'(b);
    fc = 21'(c);
    return {1'b0, fc, fb, fa};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic wait_drained();
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    wait_drained();
    repeat (20) @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOCAL:      m_focal = data;
      REG_PRINCIPAL:  m_principal = data;
      REG_RADIAL:     m_radial = data & 64'h7FFF_FFFF_FFFF_FFFF;
      REG_TANGENTIAL: m_tangential = data;
      REG_HROW0:      m_hrow[0] = data & 64'h7FFF_FFFF_FFFF_FFFF;
      REG_HROW1:      m_hrow[1] = data & 64'h7FFF_FFFF_FFFF_FFFF;
      REG_HROW2:      m_hrow[2] = data & 64'h7FFF_FFFF_FFFF_FFFF;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_pixel(logic [15:0] px, logic [15:0] py, bit typed, world_t want,
                            bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    pixel_x = px;
    pixel_y = py;
    do @(posedge clk); while (!in_ready);
    pending_points.push_back(typed ? want : predict_world(px, py));
    @(negedge clk);
    in_valid = 0;
  endtask

  // Receiver: random stalls, mostly short.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (ready_free) out_ready = 1;
      else if (hold > 0) hold--;
      else begin
        out_ready = ~out_ready;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    world_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected world point %h %h %b",
                                       world_x, world_y, invalid);
      end else begin
        e = pending_points.pop_front();
        points_checked++;
        if (invalid) invalid_seen++;
        if (world_x !== e.wx || world_y !== e.wy || invalid !== e.inv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point %0d: expected x=%h y=%h inv=%b, got x=%h y=%h inv=%b",
                     points_checked, e.wx, e.wy, e.inv, world_x, world_y, invalid);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL lens_undistort_homography_unit");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    world_t zero_bad, w;
    logic [15:0] px, py;
    int n;
    zero_bad.wx = 0;
    zero_bad.wy = 0;
    zero_bad.inv = 1;
    m_focal = 64'd4503599628419072;
    m_principal = 0;
    m_radial = 0;
    m_tangential = 0;
    m_hrow[0] = 64'd8192;
    m_hrow[1] = 64'd17179869184;
    m_hrow[2] = 64'd36028797018963968;

    // After reset the unit is a scaled identity map: world = pixel / 16 in Q16.16.
    w.inv = 0;
    w.wx = 0;        w.wy = 0;        rows.push_back('{ROW_PIX_TYPED, 0, 0, 0, 0, w});
    w.wx = 32'h10000; w.wy = 32'h20000;
    rows.push_back('{ROW_PIX_TYPED, 16'h10, 16'h20, 0, 0, w});
    // Saturated normalized coordinate at the top of the pixel range.
    w.wx = 32'h7FFFF; w.wy = 32'h7FFFF;
    rows.push_back('{ROW_PIX_TYPED, 16'hFFFF, 16'hFFFF, 0, 0, w});
    rows.push_back('{ROW_PIX, 16'h07F0, 16'h0800, 0, 0, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_PIX, 16'h0123, 16'hABCD, 0, 0, w});
    // A radial factor of exactly zero at unit radius.
    rows.push_back('{ROW_CFG, 0, 0, REG_RADIAL, pack_q3(-(1 << 17), 0, 0), w});
    rows.push_back('{ROW_PIX_TYPED, 16'h10, 16'h0, 0, 0, zero_bad});
    rows.push_back('{ROW_PIX, 16'h08, 16'h04, 0, 0, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_RADIAL, 0, w});
    // Zero perspective scale.
    rows.push_back('{ROW_CFG, 0, 0, REG_HROW2, 0, w});
    rows.push_back('{ROW_PIX_TYPED, 16'h55, 16'hAA, 0, 0, zero_bad});
    rows.push_back('{ROW_CFG, 0, 0, REG_HROW2, 64'd36028797018963968, w});
    // Zero focal length, then one zero half only.
    rows.push_back('{ROW_CFG, 0, 0, REG_FOCAL, 0, w});
    rows.push_back('{ROW_PIX_TYPED, 16'h1234, 16'h4321, 0, 0, zero_bad});
    rows.push_back('{ROW_CFG, 0, 0, REG_FOCAL, 64'h0010_0000_0000_0000, w});
    rows.push_back('{ROW_PIX_TYPED, 16'h1, 16'h1, 0, 0, zero_bad});
    // Every register at its maximum.
    rows.push_back('{ROW_CFG, 0, 0, REG_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_PRINCIPAL, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_RADIAL, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_TANGENTIAL, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_HROW0, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_HROW1, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_CFG, 0, 0, REG_HROW2, 64'hFFFF_FFFF_FFFF_FFFF, w});
    rows.push_back('{ROW_PIX, 16'h0, 16'hFFFF, 0, 0, w});
    rows.push_back('{ROW_PIX, 16'hFFFF, 16'h0, 0, 0, w});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
      else send_pixel(rows[i].px, rows[i].py, rows[i].kind == ROW_PIX_TYPED,
                      rows[i].want, 0);
    end

    for (int ph = 0; ph < 8; ph++) begin
      bit wild;
      wild = (ph == 3 || ph == 6);
      ready_free = (ph == 2);
      if (wild) begin
        write_reg(REG_FOCAL, {$urandom, $urandom});
        write_reg(REG_PRINCIPAL, {$urandom, $urandom});
        write_reg(REG_RADIAL, {$urandom, $urandom});
        write_reg(REG_TANGENTIAL, {$urandom, $urandom});
        for (int r = 0; r < 3; r++) write_reg(3'(REG_HROW0 + r), {$urandom, $urandom});
      end else begin
        // A plausible camera: pixel-sized focal lengths, mild distortion,
        // and a homography close to a scaled identity.
        write_reg(REG_FOCAL, {($urandom_range(200, 1500) << 20) + $urandom_range(0, 1 << 20),
                              ($urandom_range(200, 1500) << 20) + $urandom_range(0, 1 << 20)});
        write_reg(REG_PRINCIPAL, {32'($urandom_range(0, 1080) << 20),
                                  32'($urandom_range(0, 1920) << 20)});
        write_reg(REG_RADIAL, pack_q3($urandom_range(0, 1 << 17) - (1 << 16),
                                      $urandom_range(0, 1 << 15) - (1 << 14),
                                      $urandom_range(0, 1 << 13) - (1 << 12)));
        write_reg(REG_TANGENTIAL, {32'($urandom_range(0, 1 << 24) - (1 << 23)),
                                   32'($urandom_range(0, 1 << 24) - (1 << 23))});
        write_reg(REG_HROW0, pack_q3(8192 + $urandom_range(0, 2048) - 1024,
                                     $urandom_range(0, 1024) - 512,
                                     $urandom_range(0, 1 << 20) - (1 << 19)));
        write_reg(REG_HROW1, pack_q3($urandom_range(0, 1024) - 512,
                                     8192 + $urandom_range(0, 2048) - 1024,
                                     $urandom_range(0, 1 << 20) - (1 << 19)));
        write_reg(REG_HROW2, pack_q3($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                                     8192 + $urandom_range(0, 1024) - 512));
      end
      n = 125;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          px = 16'($urandom_range(0, 1920 * 16));
          py = 16'($urandom_range(0, 1080 * 16));
        end else begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
        // Let the pipeline drain once in the middle of a phase.
        if (ph == 4 && k == 60) begin
          in_valid = 0;
          wait_drained();
        end
        send_pixel(px, py, 0, zero_bad, ph == 2);
      end
    end
    in_valid = 0;
    ready_free = 0;

    wait_drained();
    repeat (LATENCY + 100) @(posedge clk);
    $display("Checked %0d world points (%0d flagged invalid) across %0d register writes.",
             points_checked, invalid_seen, cfg_writes);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("PASS lens_undistort_homography_unit");
    end else begin
      $display("%0d mismatches, %0d points never arrived", mismatches,
               pending_points.size());
      $display("FAIL lens_undistort_homography_unit");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/lud_pkg.sv
src/lud_div_cell.sv
src/lud_div.sv
src/lud_iter.sv
src/lens_undistort_homography_unit.sv
dv/lens_undistort_homography_unit_tb.sv
